FILE: rtl/sri_pkg.sv
// ----------------------------------------------------------------------------
// sri_pkg
// Shared types and constants of the Sellmeier refractive index pipeline.
// ----------------------------------------------------------------------------
package sri_pkg;

  // Register indexes of the configuration port.
  typedef enum logic [2:0] {
    REG_B1        = 3'd0,
    REG_B2        = 3'd1,
    REG_B3        = 3'd2,
    REG_C1        = 3'd3,
    REG_C2        = 3'd4,
    REG_C3        = 3'd5,
    REG_DISP_ON   = 3'd6,
    REG_FIXED_IDX = 3'd7
  } reg_idx_e;

  localparam int unsigned NM_W   = 12;
  localparam int unsigned IDX_W  = 24;
  localparam int unsigned B_W    = 24;
  localparam int unsigned C_W    = 32;
  localparam int unsigned CFG_W  = 32;
  localparam int unsigned LSQ_W  = 29;  // squared wavelength, Q5.24, below 2^29
  localparam int unsigned PROD_W = B_W + LSQ_W;

  // Long divider: numerator and quotient width, divisor and remainder width.
  localparam int unsigned DIV_W = 54;
  localparam int unsigned DEN_W = 33;

  // Square root: radicand, root and remainder widths.
  localparam int unsigned SQ_X_W   = 48;
  localparam int unsigned SQ_R_W   = 24;
  localparam int unsigned SQ_REM_W = 26;

  localparam int unsigned TERM_W = DIV_W + 1;
  localparam int unsigned RAD_W  = DIV_W + 3;

  // Squared wavelength scaling: nm^2 * 2^24 / 10^6 is taken as a product with
  // round(2^64 / 10^6), split in a high and a low part, and shifted down by
  // 40 bits after adding half an LSB. The reciprocal error stays far below
  // the closest distance of any exact quotient to a rounding boundary.
  localparam int unsigned KH_W      = 22;
  localparam int unsigned KL_W      = 23;
  localparam int unsigned LSQ_SH    = 40;
  localparam int unsigned LSQ_SUM_W = 70;

  localparam logic [KH_W-1:0]      LSQ_RCP_HI = 22'd2199023;
  localparam logic [KL_W-1:0]      LSQ_RCP_LO = 23'd2143726;
  localparam logic [LSQ_SUM_W-1:0] LSQ_HALF   = 70'h80_0000_0000;

  localparam logic [IDX_W-1:0] IDX_MAX = {IDX_W{1'b1}};

  // Side information of one Sellmeier term.
  typedef struct packed {
    logic neg;   // denominator below zero
    logic zero;  // denominator equal to zero
  } term_flags_t;

  // Side information that travels with the radicand.
  typedef struct packed {
    logic err;   // zero denominator or negative radicand
    logic sat;   // radicand too large, index saturates
  } sq_flags_t;

endpackage

FILE: rtl/sri_div.sv
// ----------------------------------------------------------------------------
// sri_div
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module sri_div
  import sri_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [DIV_W-1:0]   num_i,
  input  logic [DEN_W-1:0]   den_i,
  input  term_flags_t        flags_i,
  output logic               valid_o,
  output logic [DIV_W-1:0]   quot_o,
  output term_flags_t        flags_o
);

  logic              valid_q [DIV_W];
  logic [DIV_W-1:0]  work_q  [DIV_W];
  logic [DEN_W-1:0]  rem_q   [DIV_W];
  logic [DEN_W-1:0]  den_q   [DIV_W];
  term_flags_t       flags_q [DIV_W];

  for (genvar s = 0; s < DIV_W; s++) begin : g_stage
    logic              valid_in;
    logic [DIV_W-1:0]  work_in;
    logic [DEN_W-1:0]  rem_in;
    logic [DEN_W-1:0]  den_in;
    term_flags_t       flags_in;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              ge;

    if (s == 0) begin : g_first
      assign valid_in = valid_i;
      assign work_in  = num_i;
      assign rem_in   = '0;
      assign den_in   = den_i;
      assign flags_in = flags_i;
    end else begin : g_next
      assign valid_in = valid_q[s-1];
      assign work_in  = work_q[s-1];
      assign rem_in   = rem_q[s-1];
      assign den_in   = den_q[s-1];
      assign flags_in = flags_q[s-1];
    end

    assign trial = {rem_in, work_in[DIV_W-1]};
    assign ge    = trial >= {1'b0, den_in};
    assign diff  = trial - {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (en_i) begin
        valid_q[s] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        work_q[s]  <= {work_in[DIV_W-2:0], ge};
        rem_q[s]   <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        den_q[s]   <= den_in;
        flags_q[s] <= flags_in;
      end
    end
  end

  assign valid_o = valid_q[DIV_W-1];
  assign quot_o  = work_q[DIV_W-1];
  assign flags_o = flags_q[DIV_W-1];

endmodule

FILE: rtl/sri_sqrt.sv
// ----------------------------------------------------------------------------
// sri_sqrt
// Pipelined bitwise square root, one root bit per register stage, with the
// final remainder kept for rounding.
// ----------------------------------------------------------------------------
module sri_sqrt
  import sri_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [SQ_X_W-1:0]   x_i,
  input  sq_flags_t           flags_i,
  output logic                valid_o,
  output logic [SQ_R_W-1:0]   root_o,
  output logic [SQ_REM_W-1:0] rem_o,
  output sq_flags_t           flags_o
);

  logic                valid_q [SQ_R_W];
  logic [SQ_X_W-1:0]   work_q  [SQ_R_W];
  logic [SQ_REM_W-1:0] rem_q   [SQ_R_W];
  logic [SQ_R_W-1:0]   root_q  [SQ_R_W];
  sq_flags_t           flags_q [SQ_R_W];

  for (genvar s = 0; s < SQ_R_W; s++) begin : g_stage
    logic                valid_in;
    logic [SQ_X_W-1:0]   work_in;
    logic [SQ_REM_W-1:0] rem_in;
    logic [SQ_R_W-1:0]   root_in;
    sq_flags_t           flags_in;
    logic [SQ_REM_W+1:0] trial;
    logic [SQ_REM_W+1:0] test;
    logic [SQ_REM_W+1:0] diff;
    logic                ge;

    if (s == 0) begin : g_first
      assign valid_in = valid_i;
      assign work_in  = x_i;
      assign rem_in   = '0;
      assign root_in  = '0;
      assign flags_in = flags_i;
    end else begin : g_next
      assign valid_in = valid_q[s-1];
      assign work_in  = work_q[s-1];
      assign rem_in   = rem_q[s-1];
      assign root_in  = root_q[s-1];
      assign flags_in = flags_q[s-1];
    end

    assign trial = {rem_in, work_in[SQ_X_W-1 -: 2]};
    assign test  = {2'b00, root_in, 2'b01};
    assign ge    = trial >= test;
    assign diff  = trial - test;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (en_i) begin
        valid_q[s] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        work_q[s]  <= {work_in[SQ_X_W-3:0], 2'b00};
        rem_q[s]   <= ge ? diff[SQ_REM_W-1:0] : trial[SQ_REM_W-1:0];
        root_q[s]  <= {root_in[SQ_R_W-2:0], ge};
        flags_q[s] <= flags_in;
      end
    end
  end

  assign valid_o = valid_q[SQ_R_W-1];
  assign root_o  = root_q[SQ_R_W-1];
  assign rem_o   = rem_q[SQ_R_W-1];
  assign flags_o = flags_q[SQ_R_W-1];

endmodule

FILE: rtl/sellmeier_refractive_index.sv
// ----------------------------------------------------------------------------
// sellmeier_refractive_index
// Three-term Sellmeier refractive index from a wavelength in nanometres.
// ----------------------------------------------------------------------------
// The block takes one wavelength word per cycle while the output side does
// not stall, and returns one index word for each, in order. Every word
// passes through 88 register stages, most of them in the term dividers in
// series with the square root: the squared wavelength is formed by a
// multiply by the scaled reciprocal of 10^6 in three stages after the input
// register, the three Sellmeier terms are divided in three parallel 54-stage
// dividers, and the index comes from a 24-stage square root; the rest is ten
// single register stages in all. A stall on the output freezes the whole
// pipeline, so in_stall_o rises only while a finished word waits at the
// output. With the dispersive flag clear the block still runs every word
// through the pipe and returns the fixed index through the same stages.
// Configuration words are always accepted and must only be written while no
// word is in flight.
module sellmeier_refractive_index
  import sri_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // Wavelength channel.
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [NM_W-1:0]   wavelength_nm_i,
  // Index channel.
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [IDX_W-1:0]  refractive_index_o,
  output logic              math_error_o,
  // Configuration write channel.
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [2:0]        cfg_index_i,
  input  logic [CFG_W-1:0]  cfg_data_i
);

  // ---------------------------------------------------------------- registers
  logic [B_W-1:0]   coef_b_q [3];
  logic [C_W-1:0]   coef_c_q [3];
  logic             disp_on_q;
  logic [IDX_W-1:0] fixed_idx_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_b_q[0] <= 24'd1532409;
      coef_b_q[1] <= 24'd259746;
      coef_b_q[2] <= 24'd996143;
      coef_c_q[0] <= 32'd187613;
      coef_c_q[1] <= 32'd853280;
      coef_c_q[2] <= 32'd1879750956;
      disp_on_q   <= 1'b0;
      fixed_idx_q <= 24'd1048576;
    end else if (cfg_valid_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_B1:        coef_b_q[0] <= cfg_data_i[B_W-1:0];
        REG_B2:        coef_b_q[1] <= cfg_data_i[B_W-1:0];
        REG_B3:        coef_b_q[2] <= cfg_data_i[B_W-1:0];
        REG_C1:        coef_c_q[0] <= cfg_data_i;
        REG_C2:        coef_c_q[1] <= cfg_data_i;
        REG_C3:        coef_c_q[2] <= cfg_data_i;
        REG_DISP_ON:   disp_on_q   <= cfg_data_i[0];
        REG_FIXED_IDX: fixed_idx_q <= cfg_data_i[IDX_W-1:0];
      endcase
    end
  end

  // ----------------------------------------------------------- flow control
  // Every stage moves together; the pipe only halts when the output word is
  // held by the receiver.
  logic adv;
  logic out_valid_q;

  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;

  // Valid bits of the single stages.
  logic v0_q, v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q;
  logic v9;
  logic v_term [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q        <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      v6_q        <= 1'b0;
      v7_q        <= 1'b0;
      v8_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v0_q        <= in_valid_i;
      v1_q        <= v0_q;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      v5_q        <= v4_q;
      v6_q        <= v_term[0] & v_term[1] & v_term[2];
      v7_q        <= v6_q;
      v8_q        <= v7_q;
      out_valid_q <= v9;
    end
  end

  // --------------------------------------------------- squared wavelength
  logic [NM_W-1:0]           nm_q;
  logic [2*NM_W-1:0]         sq_q;
  logic [2*NM_W+KH_W-1:0]    ph_q;
  logic [2*NM_W+KL_W-1:0]    pl_q;
  logic [LSQ_SUM_W-1:0]      lsq_sum;
  logic [LSQ_W-1:0]          lsq_q;

  // nm^2 * round(2^64 / 10^6) plus half an LSB at bit 40, so the top bits
  // give nm^2 * 2^24 / 10^6 rounded to nearest.
  assign lsq_sum = {1'b0, ph_q, {KL_W{1'b0}}}
                   + {{(LSQ_SUM_W-2*NM_W-KL_W){1'b0}}, pl_q}
                   + LSQ_HALF;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      nm_q  <= wavelength_nm_i;
      sq_q  <= nm_q * nm_q;
      ph_q  <= sq_q * LSQ_RCP_HI;
      pl_q  <= sq_q * LSQ_RCP_LO;
      lsq_q <= lsq_sum[LSQ_SH +: LSQ_W];
    end
  end

  // ------------------------------------------------------- Sellmeier terms
  logic [PROD_W-1:0] prod_q  [3];
  logic [DEN_W-1:0]  d_q     [3];
  logic [DIV_W-1:0]  numr_q  [3];
  logic [DEN_W-1:0]  mag_q   [3];
  term_flags_t       tflag_q [3];
  logic [DIV_W-1:0]  quot    [3];
  term_flags_t       tflag_o [3];
  logic [TERM_W-1:0] term_q  [3];
  logic              zero_q  [3];

  for (genvar k = 0; k < 3; k++) begin : g_term
    logic [DEN_W-1:0] mag;

    assign mag = d_q[k][DEN_W-1] ? (~d_q[k] + 1'b1) : d_q[k];

    always_ff @(posedge clk_i) begin
      if (adv) begin
        prod_q[k]       <= coef_b_q[k] * lsq_q;
        d_q[k]          <= {{(DEN_W-LSQ_W){1'b0}}, lsq_q} - {1'b0, coef_c_q[k]};
        mag_q[k]        <= mag;
        // Add half the divisor so the quotient rounds half away from zero.
        numr_q[k]       <= {1'b0, prod_q[k]} + {{(DIV_W-DEN_W){1'b0}}, 1'b0,
                                                mag[DEN_W-1:1]};
        tflag_q[k].neg  <= d_q[k][DEN_W-1];
        tflag_q[k].zero <= d_q[k] == '0;
        term_q[k]       <= tflag_o[k].neg ? (~{1'b0, quot[k]} + 1'b1)
                                          : {1'b0, quot[k]};
        zero_q[k]       <= tflag_o[k].zero;
      end
    end

    sri_div u_div_term (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (v5_q),
      .num_i   (numr_q[k]),
      .den_i   (mag_q[k]),
      .flags_i (tflag_q[k]),
      .valid_o (v_term[k]),
      .quot_o  (quot[k]),
      .flags_o (tflag_o[k])
    );
  end

  // ------------------------------------------------------------ radicand
  logic [RAD_W-1:0]  rad_q;
  logic              zden_q;
  logic [SQ_X_W-1:0] x_q;
  sq_flags_t         sqf_q;
  logic              rad_neg;

  assign rad_neg = rad_q[RAD_W-1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rad_q     <= RAD_W'(1 << 20)
                   + {{(RAD_W-TERM_W){term_q[0][TERM_W-1]}}, term_q[0]}
                   + {{(RAD_W-TERM_W){term_q[1][TERM_W-1]}}, term_q[1]}
                   + {{(RAD_W-TERM_W){term_q[2][TERM_W-1]}}, term_q[2]};
      zden_q    <= zero_q[0] | zero_q[1] | zero_q[2];
      x_q       <= {rad_q[27:0], 20'd0};
      sqf_q.err <= zden_q | rad_neg;
      sqf_q.sat <= !zden_q && !rad_neg && (|rad_q[RAD_W-2:28]);
    end
  end

  // ---------------------------------------------------------- square root
  logic [SQ_R_W-1:0]   root;
  logic [SQ_REM_W-1:0] sq_rem;
  sq_flags_t           sqf_o;

  sri_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v8_q),
    .x_i     (x_q),
    .flags_i (sqf_q),
    .valid_o (v9),
    .root_o  (root),
    .rem_o   (sq_rem),
    .flags_o (sqf_o)
  );

  // ------------------------------------------------- rounding and output
  // Round to nearest: step the root up when the remainder exceeds it.
  logic [SQ_R_W:0]  rounded;
  logic [IDX_W-1:0] index_d;
  logic [IDX_W-1:0] index_q;
  logic             err_q;

  assign rounded = {1'b0, root} + {{SQ_R_W{1'b0}},
                                   ({{(SQ_REM_W-SQ_R_W){1'b0}}, root} < sq_rem)};

  always_comb begin
    if (!disp_on_q) begin
      index_d = fixed_idx_q;
    end else if (sqf_o.err) begin
      index_d = '0;
    end else if (sqf_o.sat || rounded[SQ_R_W]) begin
      index_d = IDX_MAX;
    end else begin
      index_d = rounded[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      index_q <= index_d;
      err_q   <= disp_on_q & sqf_o.err;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign refractive_index_o = index_q;
  assign math_error_o       = err_q;

  // ----------------------------------------------------------- assertions
  a_err_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && math_error_o |-> refractive_index_o == '0)
    else $error("error word with nonzero index");

  a_fixed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !disp_on_q |-> refractive_index_o == fixed_idx_q && !math_error_o)
    else $error("fixed index not returned with dispersion off");

  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held output word");

  a_terms_aligned : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_term[0] == v_term[1] && v_term[1] == v_term[2])
    else $error("term dividers out of step");

endmodule

FILE: tb/sri_index_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sri_index_checker
// Watches the wavelength, index and configuration channels of the Sellmeier
// block, computes the index of every accepted wavelength word on its own
// copy of the registers, and compares each index word in order.
// ----------------------------------------------------------------------------
module sri_index_checker
  import sri_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic [NM_W-1:0]   wavelength_nm_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [IDX_W-1:0]  refractive_index_i,
  input  logic              math_error_i,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [2:0]        cfg_index_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  output int                fail_count_o,
  output int                pending_o
);

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic             err;
  } index_word_t;

  logic [B_W-1:0]   shadow_b [3];
  logic [C_W-1:0]   shadow_c [3];
  logic             shadow_disp;
  logic [IDX_W-1:0] shadow_fixed;
  index_word_t      expected_idx_q [$];

  // Rounded-to-nearest square root of a Q.20 radicand, giving Q4.20.
  function automatic logic [IDX_W-1:0] root_q20(longint rad);
    longint x;
    longint s;
    longint t;
    x = rad <<< 20;
    s = 0;
    for (int i = 24; i >= 0; i--) begin
      t = s | (longint'(1) << i);
      if (t * t <= x) s = t;
    end
    if (x - s * s > s) s++;
    if (s > longint'(IDX_MAX)) s = longint'(IDX_MAX);
    return s[IDX_W-1:0];
  endfunction

  function automatic index_word_t sellmeier_index(logic [NM_W-1:0] nm);
    index_word_t w;
    longint      lsq;
    longint      rad;
    longint      d;
    longint      mag;
    longint      q;
    w.index = shadow_fixed;
    w.err   = 1'b0;
    if (!shadow_disp) return w;
    lsq = ((longint'(nm) * longint'(nm) <<< 24) + 500000) / 1000000;
    rad = longint'(1) << 20;
    for (int k = 0; k < 3; k++) begin
      d = lsq - longint'(shadow_c[k]);
      if (d == 0) begin
        w.index = '0;
        w.err   = 1'b1;
        return w;
      end
      mag = (d < 0) ? -d : d;
      q   = (longint'(shadow_b[k]) * lsq + mag / 2) / mag;
      rad = (d < 0) ? rad - q : rad + q;
    end
    if (rad < 0) begin
      w.index = '0;
      w.err   = 1'b1;
    end else if (rad >= (longint'(1) << 28)) begin
      w.index = IDX_MAX;
    end else begin
      w.index = root_q20(rad);
    end
    return w;
  endfunction

  assign pending_o = expected_idx_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    index_word_t exp_w;
    int          errs;
    errs = 0;
    if (!rst_ni) begin
      shadow_b[0]  <= 24'd1532409;
      shadow_b[1]  <= 24'd259746;
      shadow_b[2]  <= 24'd996143;
      shadow_c[0]  <= 32'd187613;
      shadow_c[1]  <= 32'd853280;
      shadow_c[2]  <= 32'd1879750956;
      shadow_disp  <= 1'b0;
      shadow_fixed <= 24'd1048576;
      fail_count_o <= 0;
      expected_idx_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (reg_idx_e'(cfg_index_i))
          REG_B1:        shadow_b[0]  <= cfg_data_i[B_W-1:0];
          REG_B2:        shadow_b[1]  <= cfg_data_i[B_W-1:0];
          REG_B3:        shadow_b[2]  <= cfg_data_i[B_W-1:0];
          REG_C1:        shadow_c[0]  <= cfg_data_i;
          REG_C2:        shadow_c[1]  <= cfg_data_i;
          REG_C3:        shadow_c[2]  <= cfg_data_i;
          REG_DISP_ON:   shadow_disp  <= cfg_data_i[0];
          REG_FIXED_IDX: shadow_fixed <= cfg_data_i[IDX_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        expected_idx_q.push_back(sellmeier_index(wavelength_nm_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_idx_q.size() == 0) begin
          $error("index word with no wavelength waiting: index %0d error %0d",
                 refractive_index_i, math_error_i);
          errs++;
        end else begin
          exp_w = expected_idx_q.pop_front();
          if (refractive_index_i !== exp_w.index) begin
            $error("refractive_index: expected %0d, got %0d", exp_w.index,
                   refractive_index_i);
            errs++;
          end
          if (math_error_i !== exp_w.err) begin
            $error("math_error: expected %0d, got %0d", exp_w.err, math_error_i);
            errs++;
          end
        end
      end
      if (errs != 0) begin
        fail_count_o <= fail_count_o + errs;
      end
    end
  end

endmodule

FILE: tb/sellmeier_refractive_index_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sellmeier_refractive_index_tb
// Directed and random wavelength words through the Sellmeier index block.
// ----------------------------------------------------------------------------
// The top drives stimulus only. A directed part covers the fixed index path,
// the field extremes, a zero denominator, a negative radicand, a saturated
// index and masked register writes. Random phases follow, each with its own
// register setting written while the pipe is empty, and each with its own
// pattern of sender gaps and receiver stalls. One phase holds the receiver
// off for a long stretch so the pipe fills and backs up into the input.
// The checker beside the block predicts and compares every index word.
module sellmeier_refractive_index_tb;
  import sri_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int Phases     = 12;
  localparam int PhaseWords = 135;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [NM_W-1:0]  wavelength;
  logic             out_valid;
  logic             out_stall;
  logic [IDX_W-1:0] ref_index;
  logic             math_err;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [2:0]       cfg_index;
  logic [CFG_W-1:0] cfg_data;
  int               fail_count;
  int               pending;
  int               cycles = 0;

  // Idle pattern: 0 none, 1 sender gaps, 2 receiver stalls, 3 both.
  int               idle_mode = 0;
  logic             hold_req = 1'b0;
  logic             hold_done = 1'b0;

  // Wavelengths for the reset coefficients: extremes, visible band, infrared and
  // both sides of the first pole near 105.7 nm.
  logic [NM_W-1:0] sel_list [8] = '{12'd0, 12'd4095, 12'd105, 12'd106, 12'd400,
                                    12'd589, 12'd2000, 12'd3000};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sellmeier_refractive_index dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .wavelength_nm_i    (wavelength),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .refractive_index_o (ref_index),
    .math_error_o       (math_err),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data)
  );

  sri_index_checker u_checker (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_stall_i         (in_stall),
    .wavelength_nm_i    (wavelength),
    .out_valid_i        (out_valid),
    .out_stall_i        (out_stall),
    .refractive_index_i (ref_index),
    .math_error_i       (math_err),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_i        (cfg_ready),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data),
    .fail_count_o       (fail_count),
    .pending_o          (pending)
  );

  // Squared wavelength in Q8.24, used to place a pole right on a wavelength.
  function automatic logic [C_W-1:0] lsq_of(int nm);
    longint v;
    v = ((longint'(nm) * nm <<< 24) + 500000) / 1000000;
    return v[C_W-1:0];
  endfunction

  task automatic write_reg(reg_idx_e idx, logic [CFG_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Offers one wavelength word; valid stays high into the next word unless a
  // gap is drawn there.
  task automatic send_nm(logic [NM_W-1:0] nm);
    while ((idle_mode == 1 && $urandom_range(99) < 45) ||
           (idle_mode == 3 && $urandom_range(99) < 25)) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    wavelength = nm;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Lets the pipe empty so registers can change safely.
  task automatic drain();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Receiver: random stalls per the idle pattern, plus one long hold-off.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_stall = 1'b1;
        repeat (400) @(negedge clk);
        hold_done = 1'b1;
      end
      out_stall = (idle_mode == 2) ? ($urandom_range(99) < 45) :
                  (idle_mode == 3) ? ($urandom_range(99) < 25) : 1'b0;
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    logic [C_W-1:0] pole;
    int             sel;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    wavelength = '0;
    cfg_valid  = 1'b0;
    cfg_index  = REG_B1;
    cfg_data   = '0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Reset state has dispersion off, so the fixed index comes straight out.
    send_nm(12'd0);
    send_nm(12'd4095);
    drain();
    write_reg(REG_FIXED_IDX, 32'hFFFF_FFFF);  // upper byte must be dropped
    send_nm(12'd1234);
    drain();
    write_reg(REG_FIXED_IDX, 32'd0);
    send_nm(12'd2222);
    drain();

    // Reset coefficients with the equation on, including near the first pole.
    write_reg(REG_DISP_ON, 32'hFFFF_FFFE);  // bit 0 clear: stays off
    send_nm(12'd589);
    drain();
    write_reg(REG_DISP_ON, 32'd1);
    foreach (sel_list[i]) send_nm(sel_list[i]);
    drain();

    // Pole exactly on the wavelength gives a zero denominator.
    write_reg(REG_C1, lsq_of(589));
    send_nm(12'd589);
    send_nm(12'd590);
    drain();

    // Huge positive term just past the pole saturates the index.
    write_reg(REG_B1, 32'hFF_FFFF);
    write_reg(REG_C1, lsq_of(600) - 1);
    send_nm(12'd600);
    drain();

    // Just below the pole the term turns hugely negative.
    write_reg(REG_C1, lsq_of(600) + 1);
    send_nm(12'd600);
    drain();

    // Masked writes on the other B coefficients and full-width writes on the other C ones.
    write_reg(REG_B2, 32'hAB12_3456);
    write_reg(REG_B3, 32'hFF00_0000);
    write_reg(REG_C2, 32'hFFFF_FFFF);
    write_reg(REG_C3, 32'h0000_0000);
    send_nm(12'd0);
    send_nm(12'd4095);
    send_nm(12'd1500);
    drain();

    // Random phases, each with a fresh setting and idle pattern.
    for (int p = 0; p < Phases; p++) begin
      idle_mode = p % 4;
      for (int r = 0; r < 3; r++) begin
        sel = $urandom_range(9);
        if (p == 0) begin
          write_reg(reg_idx_e'(REG_B1 + r), 32'd0);
          write_reg(reg_idx_e'(REG_C1 + r), 32'd0);
        end else if (p == 1) begin
          write_reg(reg_idx_e'(REG_B1 + r), 32'hFF_FFFF);
          write_reg(reg_idx_e'(REG_C1 + r), 32'hFFFF_FFFF);
        end else begin
          write_reg(reg_idx_e'(REG_B1 + r),
                    (sel < 3) ? $urandom() : $urandom_range(32'h20_0000));
          // Poles mostly inside the reachable range so terms change sign.
          pole = (sel < 2) ? $urandom() :
                 (sel < 4) ? lsq_of($urandom_range(4095)) :
                 $urandom_range(32'h1000_0000);
          write_reg(reg_idx_e'(REG_C1 + r), pole);
        end
      end
      write_reg(REG_DISP_ON, (p % 5 == 4) ? 32'd0 : 32'd1);
      write_reg(REG_FIXED_IDX, $urandom());
      // One phase with no idling backs the pipe up against a long hold-off.
      if (p == 4) hold_req = 1'b1;
      for (int n = 0; n < PhaseWords; n++) begin
        send_nm($urandom_range(4095));
      end
      drain();
    end

    repeat (150) @(negedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: sellmeier_refractive_index.f
rtl/sri_pkg.sv
rtl/sri_div.sv
rtl/sri_sqrt.sv
rtl/sellmeier_refractive_index.sv
tb/sri_index_checker.sv
tb/sellmeier_refractive_index_tb.sv
